/* rtl/rc_pkg.sv */
// ----------------------------------------------------------------------------
// rc_pkg: shared definitions for the relation closure block
// Default matrix size, the queue tag and byte padding of stream words.
// ----------------------------------------------------------------------------
package rc_pkg;

  // Default matrix size (rows and columns).
  localparam int RC_SIZE_N_DEF = 8;

  // Widest row index over the supported size range (up to 32 rows).
  localparam int RC_IDX_MAX_W = 5;

  // Tag that travels with each queued row: where it goes and whether it
  // closes the matrix.
  typedef struct packed {
    logic                    last;
    logic [RC_IDX_MAX_W-1:0] idx;
  } rc_tag_t;

  // Round a field width up to whole bytes.
  function automatic int pad_to_byte(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage

/* rtl/rc_front.sv */
// ----------------------------------------------------------------------------
// rc_front: row intake
// Accepts rows, tags each with its target row index and the last flag,
// and holds them in a two-entry queue for the compute side.
// ----------------------------------------------------------------------------
module rc_front import rc_pkg::*; #(
  parameter int SIZE_N = RC_SIZE_N_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SIZE_N-1:0] in_row,
  input  logic              in_last,
  output logic              q_valid,
  input  logic              q_ready,
  output logic [SIZE_N-1:0] q_row,
  output rc_tag_t           q_tag
);

  localparam int IDX_W = $clog2(SIZE_N);
  localparam logic [1:0] Q_DEPTH = 2'd2;

  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [SIZE_N-1:0] q_row_r [2];
  rc_tag_t           q_tag_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        fill_r, fill_nxt;
  logic              push, pop;
  rc_tag_t           tag_in;

  assign in_ready = (fill_r != Q_DEPTH);
  assign q_valid  = (fill_r != 2'd0);
  assign push     = in_valid & in_ready;
  assign pop      = q_valid & q_ready;
  assign q_row    = q_row_r[rd_ptr_r];
  assign q_tag    = q_tag_r[rd_ptr_r];

  always_comb begin
    tag_in.last = in_last;
    tag_in.idx  = RC_IDX_MAX_W'(cnt_r);
  end

  // Row counter: wrap after the last row slot, return to zero after a run.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      if (in_last || (cnt_r == IDX_W'(SIZE_N - 1))) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      fill_r   <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_row_r[wr_ptr_r] <= in_row;
      q_tag_r[wr_ptr_r] <= tag_in;
    end
  end

endmodule

/* rtl/rc_back.sv */
// ----------------------------------------------------------------------------
// rc_back: closure engine
// Stores rows, runs one Warshall pass per cycle over all rows, then emits
// one result per row; the final one also carries the count of ones.
// ----------------------------------------------------------------------------
module rc_back import rc_pkg::*; #(
  parameter int SIZE_N = RC_SIZE_N_DEF,
  localparam int IDX_W = $clog2(SIZE_N),
  localparam int TOT_W = $clog2(4 * SIZE_N * SIZE_N + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [SIZE_N-1:0] q_row,
  input  rc_tag_t           q_tag,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_idx,
  output logic [SIZE_N-1:0] out_orig,
  output logic [SIZE_N-1:0] out_refl,
  output logic [SIZE_N-1:0] out_symm,
  output logic [SIZE_N-1:0] out_trans,
  output logic [TOT_W-1:0]  out_total,
  output logic              out_last
);

  localparam int CNT_W = $clog2(SIZE_N + 1);
  localparam int ROW_CNT_W = $clog2(4 * SIZE_N + 1);

  typedef enum logic [1:0] {S_LOAD, S_CLOSE, S_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic [SIZE_N-1:0] rel_r [SIZE_N];
  logic [SIZE_N-1:0] rel_nxt [SIZE_N];
  logic [SIZE_N-1:0] clos_r [SIZE_N];
  logic [SIZE_N-1:0] clos_nxt [SIZE_N];
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [TOT_W-1:0]  acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [SIZE_N-1:0] out_orig_r, out_orig_nxt;
  logic [SIZE_N-1:0] out_refl_r, out_refl_nxt;
  logic [SIZE_N-1:0] out_symm_r, out_symm_nxt;
  logic [SIZE_N-1:0] out_trans_r, out_trans_nxt;
  logic [TOT_W-1:0]  out_total_r, out_total_nxt;
  logic              out_last_r, out_last_nxt;

  logic [IDX_W-1:0]     q_idx;
  logic [SIZE_N-1:0]    refl_w, symm_w;
  logic [ROW_CNT_W-1:0] row_cnt_w;
  logic                 emit_go;

  function automatic logic [CNT_W-1:0] pop_cnt(input logic [SIZE_N-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int b = 0; b < SIZE_N; b++) begin
      c = c + CNT_W'(v[b]);
    end
    return c;
  endfunction

  assign q_idx     = q_tag.idx[IDX_W-1:0];
  assign q_ready   = (state_r == S_LOAD);
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_orig  = out_orig_r;
  assign out_refl  = out_refl_r;
  assign out_symm  = out_symm_r;
  assign out_trans = out_trans_r;
  assign out_total = out_total_r;
  assign out_last  = out_last_r;

  // Row k_r of the reflexive and symmetric closures and its ones count.
  always_comb begin
    refl_w         = rel_r[k_r];
    refl_w[k_r]    = 1'b1;
    symm_w         = rel_r[k_r];
    for (int j = 0; j < SIZE_N; j++) begin
      symm_w[j] = rel_r[k_r][j] | rel_r[j][k_r];
    end
    row_cnt_w = ROW_CNT_W'(pop_cnt(rel_r[k_r])) + ROW_CNT_W'(pop_cnt(refl_w)) +
                ROW_CNT_W'(pop_cnt(symm_w)) + ROW_CNT_W'(pop_cnt(clos_r[k_r]));
  end

  always_comb begin
    state_nxt     = state_r;
    rel_nxt       = rel_r;
    clos_nxt      = clos_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_orig_nxt  = out_orig_r;
    out_refl_nxt  = out_refl_r;
    out_symm_nxt  = out_symm_r;
    out_trans_nxt = out_trans_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_LOAD: begin
        if (q_valid) begin
          rel_nxt[q_idx] = q_row;
          if (q_tag.last) begin
            // Clear rows past the last one, then seed the closure.
            for (int i = 0; i < SIZE_N; i++) begin
              if (IDX_W'(i) > q_idx) begin
                rel_nxt[i] = '0;
              end
              clos_nxt[i] = rel_nxt[i];
            end
            k_nxt     = '0;
            state_nxt = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        // One pivot per cycle; row k_r is unchanged by its own pass.
        for (int i = 0; i < SIZE_N; i++) begin
          if (clos_r[i][k_r]) begin
            clos_nxt[i] = clos_r[i] | clos_r[k_r];
          end
        end
        if (k_r == IDX_W'(SIZE_N - 1)) begin
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = k_r;
          out_orig_nxt  = rel_r[k_r];
          out_refl_nxt  = refl_w;
          out_symm_nxt  = symm_w;
          out_trans_nxt = clos_r[k_r];
          acc_nxt       = acc_r + TOT_W'(row_cnt_w);
          if (k_r == IDX_W'(SIZE_N - 1)) begin
            out_total_nxt = acc_r + TOT_W'(row_cnt_w);
            out_last_nxt  = 1'b1;
            k_nxt         = '0;
            state_nxt     = S_LOAD;
          end else begin
            out_total_nxt = '0;
            out_last_nxt  = 1'b0;
            k_nxt         = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rel_r       <= rel_nxt;
    clos_r      <= clos_nxt;
    acc_r       <= acc_nxt;
    out_idx_r   <= out_idx_nxt;
    out_orig_r  <= out_orig_nxt;
    out_refl_r  <= out_refl_nxt;
    out_symm_r  <= out_symm_nxt;
    out_trans_r <= out_trans_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

/* rtl/relation_closures.sv */
// ----------------------------------------------------------------------------
// relation_closures: reflexive, symmetric and transitive closure engine
// Loads a SIZE_N x SIZE_N boolean relation row by row and streams out one
// result per row with the original row and its three closures.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one matrix row per transaction (bit j = column j).
//   in_tlast marks the final row and starts the computation; rows missing
//   from a short matrix read as zero, extra rows wrap and overwrite row 0 onward.
//   The out_ stream returns SIZE_N transactions, row 0 first. Each holds the
//   row index, the loaded row and its reflexive, symmetric and transitive
//   closure rows. out_tlast marks the final row, which also carries the
//   count of ones over all four matrices (zero on the other rows).
// Timing:
//   Rows enter at one per cycle through a two-entry queue while the compute
//   side is loading. After the last row the Warshall unit runs one pivot per
//   cycle, then the results leave at one per cycle while out_tready is high.
//   Loading, the pivot loop and the emit phase run in turn; rows that arrive
//   after the last row wait in the queue until the emit phase ends.
// Reset and stalls:
//   rst_n (synchronous, active low) empties the queue, rewinds the row
//   counter and drops any pending result. When out_tready is low the result
//   register holds; rows keep queuing until the queue fills, then in_tready
//   drops.
// ----------------------------------------------------------------------------
module relation_closures import rc_pkg::*; #(
  parameter int SIZE_N = RC_SIZE_N_DEF,
  localparam int IDX_W = $clog2(SIZE_N),
  localparam int TOT_W = $clog2(4 * SIZE_N * SIZE_N + 1),
  localparam int IN_W = pad_to_byte(SIZE_N),
  localparam int OUT_W = pad_to_byte(IDX_W + 4 * SIZE_N + TOT_W)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // row_bits
  input  logic             in_tlast,   // last_row
  output logic             out_tvalid,
  input  logic             out_tready,
  // row_index, original_row, reflexive_row, symmetric_row, transitive_row,
  // ones_total
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast   // last_result
);

  logic              q_valid, q_ready;
  logic [SIZE_N-1:0] q_row;
  rc_tag_t           q_tag;
  logic [IDX_W-1:0]  res_idx;
  logic [SIZE_N-1:0] res_orig, res_refl, res_symm, res_trans;
  logic [TOT_W-1:0]  res_total;

  // Intake: tag rows with their slot and queue them.
  rc_front #(.SIZE_N(SIZE_N)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_row   (in_tdata[SIZE_N-1:0]),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_row    (q_row),
    .q_tag    (q_tag)
  );

  // Compute: store, close, emit.
  rc_back #(.SIZE_N(SIZE_N)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_row     (q_row),
    .q_tag     (q_tag),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_idx   (res_idx),
    .out_orig  (res_orig),
    .out_refl  (res_refl),
    .out_symm  (res_symm),
    .out_trans (res_trans),
    .out_total (res_total),
    .out_last  (out_tlast)
  );

  // Pack result fields from the lowest bit up, zero-pad to whole bytes.
  assign out_tdata = OUT_W'({res_total, res_trans, res_symm, res_refl, res_orig, res_idx});

endmodule

/* rtl/rc_checker.sv */
// ----------------------------------------------------------------------------
// rc_checker: port-level checks for relation_closures
// Watches the result stream for ordering, closure and count properties.
// ----------------------------------------------------------------------------
module rc_checker import rc_pkg::*; #(
  parameter int SIZE_N = RC_SIZE_N_DEF,
  localparam int IDX_W = $clog2(SIZE_N),
  localparam int TOT_W = $clog2(4 * SIZE_N * SIZE_N + 1),
  localparam int OUT_W = pad_to_byte(IDX_W + 4 * SIZE_N + TOT_W)
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  localparam int ORIG_LO  = IDX_W;
  localparam int REFL_LO  = IDX_W + SIZE_N;
  localparam int TRANS_LO = IDX_W + 3 * SIZE_N;
  localparam int TOT_LO   = IDX_W + 4 * SIZE_N;

  logic [IDX_W-1:0]  c_idx;
  logic [SIZE_N-1:0] c_orig, c_refl, c_trans;
  logic [TOT_W-1:0]  c_total;

  assign c_idx   = out_tdata[IDX_W-1:0];
  assign c_orig  = out_tdata[ORIG_LO +: SIZE_N];
  assign c_refl  = out_tdata[REFL_LO +: SIZE_N];
  assign c_trans = out_tdata[TRANS_LO +: SIZE_N];
  assign c_total = out_tdata[TOT_LO +: TOT_W];

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Only the final row of a run carries the ones count.
  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> c_total == '0)
    else $error("ones count on a non-final row");

  // The final result is the last matrix row.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> c_idx == IDX_W'(SIZE_N - 1))
    else $error("final result has wrong row index");

  // Reflexive row has its diagonal set.
  a_refl_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> c_refl[c_idx])
    else $error("reflexive row misses its diagonal");

  // The transitive closure contains the original relation.
  a_trans_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (c_orig & ~c_trans) == '0)
    else $error("transitive row drops an original pair");

endmodule

bind relation_closures rc_checker #(.SIZE_N(SIZE_N)) u_rc_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for relation_closures
// Streams boolean relation matrices row by row, predicts the reflexive,
// symmetric and transitive closure rows plus the ones count, and compares
// every result transaction field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import rc_pkg::*;

  localparam int SIZE_N     = RC_SIZE_N_DEF;
  localparam int ROW_W      = SIZE_N;
  localparam int IDX_W      = $clog2(SIZE_N);
  localparam int TOT_W      = $clog2(4 * SIZE_N * SIZE_N + 1);
  localparam int IN_W       = ((ROW_W + 7) / 8) * 8;
  localparam int RES_W      = IDX_W + 4 * ROW_W + TOT_W;
  localparam int OUT_W      = ((RES_W + 7) / 8) * 8;
  localparam int STALL_MAX  = 2000;
  localparam int DRAIN_CYC  = 2 * SIZE_N + 8;
  localparam int RAND_ITEMS = 80;

  // One row on its way into the block.
  typedef struct {
    logic [ROW_W-1:0] row_bits;
    logic             last_row;
  } matrix_row_t;

  // One result row; packed in out_tdata order with out_tlast on top.
  typedef struct packed {
    logic             last_result;
    logic [TOT_W-1:0] ones_total;
    logic [ROW_W-1:0] transitive_row;
    logic [ROW_W-1:0] symmetric_row;
    logic [ROW_W-1:0] reflexive_row;
    logic [ROW_W-1:0] original_row;
    logic [IDX_W-1:0] row_index;
  } row_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // row_bits
  logic             in_tlast = 1'b0; // last_row
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // row_index, original_row, reflexive_row,
                                     // symmetric_row, transitive_row, ones_total
  logic             out_tlast;       // last_result

  matrix_row_t      rows_to_send[$];
  row_result_t      closure_rows_due[$];

  // Predicted block state: loaded rows and the next load slot.
  logic [ROW_W-1:0] relation[SIZE_N] = '{default: '0};
  int unsigned      load_idx = 0;

  int unsigned      cyc = 0;
  int unsigned      stall_cnt = 0;
  int unsigned      err_cnt = 0;
  bit               timed_out = 1'b0;
  row_result_t      got;
  row_result_t      want;

  relation_closures dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Idle about a quarter of the time, except in one steady window.
  function automatic bit take_break();
    bit steady;
    steady = (cyc >= 300) && (cyc < 700);
    return !steady && ($urandom_range(0, 99) < 24);
  endfunction

  // Store a row; on the last row, close the matrix and queue its results.
  task automatic close_matrix_row(input logic [ROW_W-1:0] row, input logic fin);
    logic [ROW_W-1:0] refl[SIZE_N];
    logic [ROW_W-1:0] symm[SIZE_N];
    logic [ROW_W-1:0] reach[SIZE_N];
    int unsigned      total;
    row_result_t      res;
    relation[load_idx] = row;
    if (!fin) begin
      load_idx = (load_idx + 1) % SIZE_N;
      return;
    end
    // short matrix: rows after the last one read as zero
    for (int i = load_idx + 1; i < SIZE_N; i++) relation[i] = '0;
    for (int i = 0; i < SIZE_N; i++) begin
      refl[i] = relation[i];
      refl[i][i] = 1'b1;
      symm[i] = relation[i];
      for (int j = 0; j < SIZE_N; j++) begin
        if (relation[j][i]) symm[i][j] = 1'b1;
      end
      reach[i] = relation[i];
    end
    // Warshall: allow pivot k as an intermediate node, one pivot at a time
    for (int k = 0; k < SIZE_N; k++) begin
      for (int i = 0; i < SIZE_N; i++) begin
        if (reach[i][k]) reach[i] = reach[i] | reach[k];
      end
    end
    total = 0;
    for (int i = 0; i < SIZE_N; i++) begin
      total += $countones(relation[i]) + $countones(refl[i]) +
               $countones(symm[i]) + $countones(reach[i]);
    end
    for (int i = 0; i < SIZE_N; i++) begin
      res.row_index      = IDX_W'(i);
      res.original_row   = relation[i];
      res.reflexive_row  = refl[i];
      res.symmetric_row  = symm[i];
      res.transitive_row = reach[i];
      res.ones_total     = (i == SIZE_N - 1) ? TOT_W'(total) : '0;
      res.last_result    = (i == SIZE_N - 1);
      closure_rows_due.push_back(res);
    end
    load_idx = 0;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v,
               act_v);
      err_cnt++;
    end
  endtask

  function automatic void queue_row(input logic [ROW_W-1:0] row, input logic fin);
    matrix_row_t item;
    item.row_bits = row;
    item.last_row = fin;
    rows_to_send.push_back(item);
  endfunction

  // Sparse rows give long reachability chains worth closing.
  function automatic logic [ROW_W-1:0] sparse_row();
    logic [ROW_W-1:0] r;
    for (int b = 0; b < ROW_W; b++) r[b] = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  // Fill the stimulus queue: directed matrices first, then random ones.
  initial begin
    int unsigned n_items;
    int unsigned len;
    int unsigned style;
    logic [ROW_W-1:0] row;
    // single-row matrices: all columns set, then none
    queue_row('1, 1'b1);
    queue_row('0, 1'b1);
    // ring: row i reaches row i+1, the last row closes back to row 0
    for (int i = 0; i < SIZE_N; i++) begin
      row = '0;
      row[(i + 1) % SIZE_N] = 1'b1;
      queue_row(row, i == SIZE_N - 1);
    end
    // too many rows: two extra rows wrap and overwrite rows 0 and 1
    for (int i = 0; i < SIZE_N + 2; i++) begin
      row = (i % 2) ? ROW_W'(8'hA5) : ROW_W'(8'h5A);
      row[i % SIZE_N] = 1'b0;
      queue_row(row, i == SIZE_N + 1);
    end
    n_items = 0;
    while (n_items < RAND_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(SIZE_N + 1, SIZE_N + 5)
                                        : $urandom_range(1, SIZE_N);
      style = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: row = ROW_W'($urandom);
          1: row = ($urandom_range(0, 3) == 0) ? ROW_W'($urandom) : '0;
          default: row = sparse_row();
        endcase
        queue_row(row, i == len - 1);
      end
      n_items += len;
    end
  end

  // Driver: hold each row until its transaction completes, then advance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) close_matrix_row(in_tdata[ROW_W-1:0], in_tlast);
      if (!in_tvalid || in_tready) begin
        if (rows_to_send.size() != 0 && !take_break()) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_W'(rows_to_send[0].row_bits);
          in_tlast  <= rows_to_send[0].last_row;
          void'(rows_to_send.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = row_result_t'({out_tlast, out_tdata[RES_W-1:0]});
        if (closure_rows_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
          err_cnt++;
        end else begin
          want = closure_rows_due.pop_front();
          check_field("row_index", want.row_index, got.row_index);
          check_field("original_row", want.original_row, got.original_row);
          check_field("reflexive_row", want.reflexive_row, got.reflexive_row);
          check_field("symmetric_row", want.symmetric_row, got.symmetric_row);
          check_field("transitive_row", want.transitive_row, got.transitive_row);
          check_field("ones_total", want.ones_total, got.ones_total);
          check_field("last_result", want.last_result, got.last_result);
        end
      end
      out_tready <= !take_break();
    end
  end

  // Watchdog: count cycles with no transaction on either side.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) timed_out <= 1'b1;
    end
  end

  // Reset, wait for the stimulus to drain and the predictions to clear, report.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (!timed_out && (rows_to_send.size() != 0 || in_tvalid ||
                          closure_rows_due.size() != 0)) @(negedge clk);
    if (!timed_out) repeat (DRAIN_CYC) @(negedge clk);
    if (!timed_out && err_cnt == 0 && closure_rows_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/rc_pkg.sv
rtl/rc_front.sv
rtl/rc_back.sv
rtl/relation_closures.sv
rtl/rc_checker.sv
tb/sv/tb.sv
